/* sv/table_linear_interpolator_macros.svh */
// Assertion macros for the table interpolator
`ifndef TABLE_LINEAR_INTERPOLATOR_MACROS_SVH
`define TABLE_LINEAR_INTERPOLATOR_MACROS_SVH
`ifndef SYNTHESIS
`define TLI_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define TLI_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define TLI_ASSERT_IMP(label, clk, rst, a, b)
`define TLI_ASSERT_NXT(label, clk, rst, a, b)
`endif
`endif

/* sv/tli_pkg.sv */
// ----------------------------------------------------------------------------
// tli_pkg
// Types and constants shared by the table interpolator.
// ----------------------------------------------------------------------------
package tli_pkg;
  localparam int MaxPoints = 256;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = IdxW + 1;
  localparam logic signed [31:0] Marker = -32'sd65470464;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_ENDS, ST_WAIT_ENDS, ST_CHECK, ST_SRCH_RD, ST_SRCH_WAIT,
    ST_BRK_RD, ST_BRK_WAIT, ST_EVAL, ST_MUL, ST_DIV, ST_SUM, ST_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [65:0]       dividend;
    logic [32:0]       divisor;
  } div_req_t;
endpackage

/* sv/tli_if.sv */
// ----------------------------------------------------------------------------
// tli_in_if / tli_out_if / tli_cfg_if
// Valid/ready channels of the table interpolator.
// ----------------------------------------------------------------------------
interface tli_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  point_index;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] query_x;
  modport source (output valid, operation, point_index, point_x, point_y, query_x,
                  input ready);
  modport sink (input valid, operation, point_index, point_x, point_y, query_x,
                output ready);
endinterface

interface tli_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] interp_value;
  logic        error_flag;
  modport source (output valid, interp_value, error_flag, input ready);
  modport sink (input valid, interp_value, error_flag, output ready);
endinterface

interface tli_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* sv/tli_ram.sv */
// ----------------------------------------------------------------------------
// tli_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module tli_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* sv/tli_div.sv */
// ----------------------------------------------------------------------------
// tli_div
// Restoring divider, one quotient bit per cycle, clamped to 2^41.
// ----------------------------------------------------------------------------
module tli_div (
  input  logic               clk,
  input  logic               rst,
  input  tli_pkg::div_req_t  req,
  output logic               done,
  output logic [41:0]        quot
);
  logic [65:0] dvd;
  logic [33:0] rem;
  logic [32:0] dsr;
  logic [6:0]  cnt;
  logic        busy;
  logic        big;
  logic [40:0] qacc;
  logic [33:0] trial;
  logic [34:0] diff;

  always_comb begin
    trial = {rem[32:0], dvd[65]};
    diff  = {1'b0, trial} - {2'b0, dsr};
  end

  // any quotient bit at 2^41 or above clamps the result
  assign quot = big ? (42'd1 << 41) : {1'b0, qacc};

  // one bit a cycle, MSB first; done pulses as busy drops after the last bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      big  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        dvd  <= req.dividend;
        dsr  <= req.divisor;
        rem  <= '0;
        cnt  <= 7'd65;
        big  <= 1'b0;
        qacc <= '0;
      end else if (busy) begin
        dvd <= {dvd[64:0], 1'b0};
        if (!diff[34]) begin
          rem <= diff[33:0];
          if (cnt >= 7'd41) big <= 1'b1;
          else qacc[cnt[5:0]] <= 1'b1;
        end else begin
          rem <= trial;
        end
        if (cnt == 7'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 7'd1;
      end
    end
  end
endmodule

/* sv/table_linear_interpolator.sv */
// ----------------------------------------------------------------------------
// table_linear_interpolator
// Piecewise linear interpolation over a table held in two RAMs.
// ----------------------------------------------------------------------------
// Query path: IDLE, RD_ENDS, WAIT_ENDS, CHECK; end points and out-of-range x
// go to OUT. Else k search steps of SRCH_RD, SRCH_WAIT, CHECK (up to 8 at 256
// points), then BRK_RD, BRK_WAIT, EVAL; a missing y or a non-increasing
// interval goes to OUT, else MUL, DIV, SUM, OUT. A write item gives no result.
// Throughput: one word in flight; next word taken after the result leaves.
// Reset: rst synchronous; point_count returns to 2, table RAMs are not cleared.
`include "table_linear_interpolator_macros.svh"
module table_linear_interpolator (
  input logic clk,
  input logic rst,
  tli_in_if.sink    in_ch,
  tli_out_if.source out_ch,
  tli_cfg_if.sink   cfg
);
  localparam int IW = tli_pkg::IdxW;
  localparam int CW = tli_pkg::CntW;

  tli_pkg::state_t state, state_next;
  logic [CW-1:0] point_count;
  logic [CW-1:0] n_eff;
  logic [IW-1:0] lo, hi, mid;
  logic [IW-1:0] addr;
  logic          we;
  logic [31:0]   xr, yr;
  logic signed [31:0] q, x0, y0, xl, yl;
  logic [IW:0]   sum_lh;
  logic signed [32:0] da, db;
  logic [32:0]   ma, mb, dx;
  logic          neg;
  tli_pkg::div_req_t dreq;
  logic          ddone;
  logic [41:0]   dq;
  logic signed [42:0] r;
  logic signed [31:0] res;
  logic          err;

  // config only between items, never in the cycle a word is offered
  assign cfg.ready = (state == tli_pkg::ST_IDLE) && !in_ch.valid;
  always_ff @(posedge clk) begin
    if (rst) point_count <= CW'(2);
    else if (cfg.valid && cfg.ready) point_count <= cfg.data;
  end
  // effective count, clamped to 2..MaxPoints
  always_comb begin
    if (point_count < CW'(2)) n_eff = CW'(2);
    else if (point_count > CW'(tli_pkg::MaxPoints)) n_eff = CW'(tli_pkg::MaxPoints);
    else n_eff = point_count;
  end

  // memories
  assign we = (state == tli_pkg::ST_IDLE) && in_ch.valid &&
              (in_ch.operation == tli_pkg::OP_WRITE);
  always_comb begin
    case (state)
      tli_pkg::ST_IDLE:
        addr = (in_ch.operation == tli_pkg::OP_WRITE) ? in_ch.point_index : '0;
      tli_pkg::ST_RD_ENDS:  addr = IW'(n_eff - CW'(1));
      tli_pkg::ST_SRCH_RD:  addr = mid;
      tli_pkg::ST_BRK_RD:   addr = hi;
      default:              addr = lo;
    endcase
  end
  tli_ram #(.Width(32), .Depth(tli_pkg::MaxPoints)) u_x (
    .clk(clk), .we(we), .addr(addr), .wdata(in_ch.point_x), .rdata(xr));
  tli_ram #(.Width(32), .Depth(tli_pkg::MaxPoints)) u_y (
    .clk(clk), .we(we), .addr(addr), .wdata(in_ch.point_y), .rdata(yr));

  assign sum_lh = {1'b0, lo} + {1'b0, hi};
  assign mid = sum_lh[IW:1];
  assign in_ch.ready = (state == tli_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tli_pkg::ST_IDLE:
        if (in_ch.valid && in_ch.operation == tli_pkg::OP_QUERY)
          state_next = tli_pkg::ST_RD_ENDS;
      tli_pkg::ST_RD_ENDS:   state_next = tli_pkg::ST_WAIT_ENDS;
      tli_pkg::ST_WAIT_ENDS: state_next = tli_pkg::ST_CHECK;
      tli_pkg::ST_CHECK: begin
        if (q == x0 || q == xl || q < x0 || q > xl) state_next = tli_pkg::ST_OUT;
        else if (hi - lo > IW'(1)) state_next = tli_pkg::ST_SRCH_RD;
        else state_next = tli_pkg::ST_BRK_RD;
      end
      tli_pkg::ST_SRCH_RD:   state_next = tli_pkg::ST_SRCH_WAIT;
      tli_pkg::ST_SRCH_WAIT: state_next = tli_pkg::ST_CHECK;
      tli_pkg::ST_BRK_RD:    state_next = tli_pkg::ST_BRK_WAIT;
      tli_pkg::ST_BRK_WAIT:  state_next = tli_pkg::ST_EVAL;
      tli_pkg::ST_EVAL:
        if (y0 == tli_pkg::Marker || yl == tli_pkg::Marker || xl <= x0)
          state_next = tli_pkg::ST_OUT;
        else state_next = tli_pkg::ST_MUL;
      tli_pkg::ST_MUL: state_next = tli_pkg::ST_DIV;
      tli_pkg::ST_DIV: if (ddone) state_next = tli_pkg::ST_SUM;
      tli_pkg::ST_SUM: state_next = tli_pkg::ST_OUT;
      tli_pkg::ST_OUT: if (out_ch.ready) state_next = tli_pkg::ST_IDLE;
      default: state_next = tli_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= tli_pkg::ST_IDLE;
    else state <= state_next;
  end

  // datapath; x0/y0 hold lo entry, xl/yl the hi entry
  assign da = 33'(q) - 33'(x0);
  assign db = 33'(yl) - 33'(y0);
  assign dx = 33'(xl) - 33'(x0);
  always_ff @(posedge clk) begin
    case (state)
      tli_pkg::ST_IDLE: begin
        q  <= in_ch.query_x;
        lo <= '0;
        hi <= IW'(n_eff - CW'(1));
      end
      tli_pkg::ST_RD_ENDS: ;
      tli_pkg::ST_WAIT_ENDS: begin
        // last entry arrives; entry 0 was taken in RD_ENDS
        xl <= xr;
        yl <= yr;
      end
      tli_pkg::ST_CHECK: begin
        if (q == x0) begin
          res <= y0; err <= (y0 == tli_pkg::Marker);
        end else if (q == xl) begin
          res <= yl; err <= (yl == tli_pkg::Marker);
        end else begin
          res <= tli_pkg::Marker; err <= 1'b1;
        end
      end
      tli_pkg::ST_SRCH_WAIT: begin
        if ($signed(q) >= $signed(xr)) lo <= mid;
        else hi <= mid;
      end
      tli_pkg::ST_BRK_WAIT: begin
        xl <= xr;
        yl <= yr;
      end
      tli_pkg::ST_EVAL: begin
        res <= tli_pkg::Marker; err <= 1'b1;
        ma <= da[32] ? 33'(-da) : 33'(da);
        mb <= db[32] ? 33'(-db) : 33'(db);
        neg <= da[32] ^ db[32];
      end
      tli_pkg::ST_SUM: begin
        err <= 1'b0;
        if (r > 43'sd2147483647) res <= 32'h7fffffff;
        else if (r < -43'sd2147483648) res <= 32'h80000000;
        else res <= r[31:0];
      end
      default: ;
    endcase
  end

  // lo entry: entry 0 from the IDLE read, bracket lo from the CHECK read
  always_ff @(posedge clk) begin
    if (state == tli_pkg::ST_RD_ENDS || state == tli_pkg::ST_BRK_RD) begin
      x0 <= xr;
      y0 <= yr;
    end
  end

  assign r = neg ? 43'(y0) - $signed({1'b0, dq}) : 43'(y0) + $signed({1'b0, dq});

  // product feeds the divider directly in the start cycle
  assign dreq.start    = (state == tli_pkg::ST_MUL);
  assign dreq.dividend = 66'(ma) * 66'(mb);
  assign dreq.divisor  = dx;
  tli_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quot(dq));

  assign out_ch.valid = (state == tli_pkg::ST_OUT);
  assign out_ch.interp_value = res;
  assign out_ch.error_flag = err;

  `TLI_ASSERT_IMP(a_no_in_busy, clk, rst, state != tli_pkg::ST_IDLE, !in_ch.ready)
  `TLI_ASSERT_IMP(a_err_marker, clk, rst, out_ch.valid && out_ch.error_flag,
                  out_ch.interp_value == tli_pkg::Marker)
  `TLI_ASSERT_NXT(a_out_hold, clk, rst, out_ch.valid && !out_ch.ready, out_ch.valid)
endmodule
